### design/hte_pkg.sv
// Shared types, register indexes and arithmetic helpers for the heightfield elevation block.
package hte_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_GRID_SIZE    = 2'd0;
  localparam logic [1:0] CFG_CELL_SIZE    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd2;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Largest elevation that fits the unsigned Q16.8 result.
  localparam logic [23:0] ELEV_MAX = 24'hFFFFFF;

  // Number of quotient bits resolved in one pipeline stage.
  localparam int DIV_BITS_PER_STAGE = 8;

  // Partial state of a restoring divider with a 24-bit dividend and a 16-bit divisor.
  typedef struct packed {
    logic [16:0] rem;
    logic [23:0] quo;
  } div_t;

  // Eight restoring division steps. The dividend bits shift out of quo from the top
  // while the quotient bits shift in at the bottom.
  function automatic div_t div_steps(div_t s, logic [15:0] d);
    div_t        r;
    logic [16:0] t;
    r = s;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t = {r.rem[15:0], r.quo[23]};
      r.quo = {r.quo[22:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        r.quo[0] = 1'b1;
      end
      r.rem = t;
    end
    return r;
  endfunction

endpackage

### design/hte_ram.sv
// Generic single write port, single read port RAM with registered read data.
module hte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/heightfield_triangle_elevation.sv
// Top level of the heightfield triangle elevation pipeline.
// The block takes one request per clock and never asserts busy. A write request stores one
// height sample. A query request returns its elevation on elevation, with done high for
// one cycle, in request order. The pipeline holds two 24-bit restoring dividers (cell
// index, then final plane division), each spread over three stages of eight steps, plus
// the sample read from three copies of the height memory.
// Writes reach the memory at the same stage where queries read it, so a query sees every
// write that was accepted before it. Configuration may only change while no query is in flight.
module heightfield_triangle_elevation #(
  parameter int MAX_GRID = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [15:0] sample_address,
  input  logic [7:0]  sample_height,
  input  logic [23:0] query_x,
  input  logic [23:0] query_depth,
  output logic        done,
  output logic [23:0] elevation,
  input  logic        config_write,
  input  logic [1:0]  config_index,
  input  logic [15:0] config_data
);

  localparam int DEPTH = MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int GW    = $clog2(MAX_GRID + 1);
  localparam int RW    = $clog2(MAX_GRID);

  // Configuration registers.
  logic [8:0]  grid_size;
  logic [15:0] cell_size;
  logic [15:0] height_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size    <= 9'd256;
      cell_size    <= 16'd256;
      height_scale <= 16'd256;
    end else if (config_write) begin
      unique case (config_index)
        hte_pkg::CFG_GRID_SIZE:    grid_size    <= config_data[8:0];
        hte_pkg::CFG_CELL_SIZE:    cell_size    <= config_data;
        hte_pkg::CFG_HEIGHT_SCALE: height_scale <= config_data;
        default: ;
      endcase
    end
  end

  // Effective cell size and grid side.
  logic [15:0]   cell_eff;
  logic [31:0]   grid32;
  logic [GW-1:0] grid;

  always_comb begin
    cell_eff = (cell_size == 16'd0) ? 16'd1 : cell_size;
    if (grid_size == 9'd0) begin
      grid32 = 32'd1;
    end else if ({23'd0, grid_size} > 32'(MAX_GRID)) begin
      grid32 = 32'(MAX_GRID);
    end else begin
      grid32 = {23'd0, grid_size};
    end
    grid = grid32[GW-1:0];
  end

  assign busy = 1'b0;

  // Stages 0..3: input register and the cell index dividers.
  logic              v_d   [0:3];
  logic              op_d  [0:3];
  logic [15:0]       adr_d [0:3];
  logic [7:0]        hgt_d [0:3];
  logic              sx_d  [0:3];
  logic              sz_d  [0:3];
  hte_pkg::div_t     xdiv  [0:3];
  hte_pkg::div_t     zdiv  [0:3];
  hte_pkg::div_t     xdiv_next [1:3];
  hte_pkg::div_t     zdiv_next [1:3];

  always_comb begin
    for (int k = 1; k < 4; k++) begin
      xdiv_next[k] = hte_pkg::div_steps(xdiv[k-1], cell_eff);
      zdiv_next[k] = hte_pkg::div_steps(zdiv[k-1], cell_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        v_d[k] <= 1'b0;
      end
    end else begin
      v_d[0] <= start && !busy;
      for (int k = 1; k < 4; k++) begin
        v_d[k] <= v_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_d[0]  <= operation;
    adr_d[0] <= sample_address;
    hgt_d[0] <= sample_height;
    sx_d[0]  <= query_x[23];
    sz_d[0]  <= query_depth[23];
    xdiv[0]  <= '{rem: 17'd0, quo: query_x[23] ? (~query_x + 24'd1) : query_x};
    zdiv[0]  <= '{rem: 17'd0, quo: query_depth[23] ? (~query_depth + 24'd1) : query_depth};
    for (int k = 1; k < 4; k++) begin
      op_d[k]  <= op_d[k-1];
      adr_d[k] <= adr_d[k-1];
      hgt_d[k] <= hgt_d[k-1];
      sx_d[k]  <= sx_d[k-1];
      sz_d[k]  <= sz_d[k-1];
      xdiv[k]  <= xdiv_next[k];
      zdiv[k]  <= zdiv_next[k];
    end
  end

  // Signed cell indexes and in-cell offsets from the quotients and remainders.
  logic signed [24:0] col_c, row_c;
  logic signed [16:0] u_c, v_c;

  always_comb begin
    col_c = sx_d[3] ? -$signed({1'b0, xdiv[3].quo}) : $signed({1'b0, xdiv[3].quo});
    row_c = sz_d[3] ? -$signed({1'b0, zdiv[3].quo}) : $signed({1'b0, zdiv[3].quo});
    u_c   = sx_d[3] ? -$signed(xdiv[3].rem) : $signed(xdiv[3].rem);
    v_c   = sz_d[3] ? -$signed(zdiv[3].rem) : $signed(zdiv[3].rem);
  end

  // Stage 4: cell position registered, memory accessed.
  logic               v4, op4, sel4;
  logic [15:0]        adr4;
  logic [7:0]         hgt4;
  logic signed [24:0] col4, row4;
  logic signed [16:0] u4, v4off;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v_d[3];
    end
  end

  always_ff @(posedge clk) begin
    op4   <= op_d[3];
    adr4  <= adr_d[3];
    hgt4  <= hgt_d[3];
    col4  <= col_c;
    row4  <= row_c;
    u4    <= u_c;
    v4off <= v_c;
    sel4  <= u_c < v_c;
  end

  function automatic logic in_grid(logic signed [24:0] idx, logic [GW-1:0] g);
    return !idx[24] && (idx[23:0] < 24'(g));
  endfunction

  function automatic logic [AW-1:0] corner_addr(logic signed [24:0] r, logic signed [24:0] c,
                                                logic [GW-1:0] g);
    logic [RW+GW-1:0] prod;
    prod = r[RW-1:0] * g;
    return AW'(prod) + AW'(c[RW-1:0]);
  endfunction

  // Corner selection: the third corner is (c,r+1) below the diagonal, else (c+1,r).
  logic signed [24:0] row1, col1, rowx, colx;
  logic               ok00, ok11, okx;
  logic [AW-1:0]      a00, a11, ax;
  logic [31:0]        wadr32;
  logic               ram_we;

  always_comb begin
    row1   = row4 + 25'sd1;
    col1   = col4 + 25'sd1;
    rowx   = sel4 ? row1 : row4;
    colx   = sel4 ? col4 : col1;
    ok00   = in_grid(row4, grid) && in_grid(col4, grid);
    ok11   = in_grid(row1, grid) && in_grid(col1, grid);
    okx    = in_grid(rowx, grid) && in_grid(colx, grid);
    a00    = corner_addr(row4, col4, grid);
    a11    = corner_addr(row1, col1, grid);
    ax     = corner_addr(rowx, colx, grid);
    wadr32 = {16'd0, adr4};
    ram_we = v4 && (op4 == hte_pkg::OP_WRITE) && (wadr32 < 32'(DEPTH));
  end

  logic [7:0] r00, r11, rx;

  hte_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram00 (
    .clk(clk), .we(ram_we), .waddr(wadr32[AW-1:0]), .wdata(hgt4), .raddr(a00), .rdata(r00)
  );
  hte_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram11 (
    .clk(clk), .we(ram_we), .waddr(wadr32[AW-1:0]), .wdata(hgt4), .raddr(a11), .rdata(r11)
  );
  hte_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ramx (
    .clk(clk), .we(ram_we), .waddr(wadr32[AW-1:0]), .wdata(hgt4), .raddr(ax), .rdata(rx)
  );

  // Stage 5: sample data arrives from memory.
  logic               v5, sel5, ok00_5, ok11_5, okx_5;
  logic signed [16:0] u5, v5off;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4 && (op4 == hte_pkg::OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    sel5   <= sel4;
    ok00_5 <= ok00;
    ok11_5 <= ok11;
    okx_5  <= okx;
    u5     <= u4;
    v5off  <= v4off;
  end

  // Stage 6: corner heights scaled.
  logic               v6, sel6;
  logic [23:0]        h00, h11, hx;
  logic signed [16:0] u6, v6off;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    h00   <= ok00_5 ? r00 * height_scale : 24'd0;
    h11   <= ok11_5 ? r11 * height_scale : 24'd0;
    hx    <= okx_5 ? rx * height_scale : 24'd0;
    sel6  <= sel5;
    u6    <= u5;
    v6off <= v5off;
  end

  // Stage 7: plane terms multiplied.
  logic signed [24:0] dx, dy;
  logic signed [16:0] mu, mv;

  always_comb begin
    dx = $signed({1'b0, hx}) - $signed({1'b0, h00});
    dy = $signed({1'b0, h11}) - $signed({1'b0, hx});
    mu = sel6 ? v6off : u6;
    mv = sel6 ? u6 : v6off;
  end

  logic               v7;
  logic [39:0]        p0;
  logic signed [41:0] m1, m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    p0 <= h00 * cell_eff;
    m1 <= dx * mu;
    m2 <= dy * mv;
  end

  // Stage 8: numerator summed.
  logic               v8;
  logic signed [43:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    num <= $signed({4'd0, p0}) + 44'(m1) + 44'(m2);
  end

  // Stages F0..F3: clamp decisions and the final division by the cell size.
  logic          fv    [0:3];
  logic          fneg  [0:3];
  logic          fsat  [0:3];
  hte_pkg::div_t fdiv  [0:3];
  hte_pkg::div_t fdiv_next [1:3];

  always_comb begin
    for (int k = 1; k < 4; k++) begin
      fdiv_next[k] = hte_pkg::div_steps(fdiv[k-1], cell_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        fv[k] <= 1'b0;
      end
    end else begin
      fv[0] <= v8;
      for (int k = 1; k < 4; k++) begin
        fv[k] <= fv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    fneg[0] <= num <= 44'sd0;
    fsat[0] <= num >= $signed({4'd0, cell_eff, 24'd0});
    fdiv[0] <= '{rem: {1'b0, num[39:24]}, quo: num[23:0]};
    for (int k = 1; k < 4; k++) begin
      fneg[k] <= fneg[k-1];
      fsat[k] <= fsat[k-1];
      fdiv[k] <= fdiv_next[k];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fv[3];
    end
  end

  always_ff @(posedge clk) begin
    priority if (fneg[3]) begin
      elevation <= 24'd0;
    end else if (fsat[3]) begin
      elevation <= hte_pkg::ELEV_MAX;
    end else begin
      elevation <= fdiv[3].quo;
    end
  end

endmodule

### design/hte_checker.sv
// Port-level checks of request to result timing for the heightfield elevation block.
module hte_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic done
);

  // Rising edges from the accepting edge to the edge that takes the result.
  localparam int LAT = 14;

  // Every result belongs to a query accepted a fixed latency earlier.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (operation == hte_pkg::OP_QUERY), LAT))
    else $error("result without a matching query");

  // Every accepted query gives a result after the fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == hte_pkg::OP_QUERY)) |-> ##LAT done)
    else $error("query lost");

  // A write request gives no result.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == hte_pkg::OP_WRITE)) |-> ##LAT !done)
    else $error("result from a write request");

endmodule

bind heightfield_triangle_elevation hte_checker u_hte_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation), .done(done)
);
